// ----- rtl/core/bhc_pkg.sv -----
// Package for the byte histogram counter.
// Holds the beat field widths, the mode and result kind codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned KIND_W      = 1;
  localparam int unsigned OUT_CNT_W   = 32;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READOUT = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_t;

  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

endpackage

`default_nettype wire

// ----- rtl/core/bhc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/byte_histogram_counter_unit.sv -----
// Top level of the byte histogram counter: stream ports, bin update pipeline, output register.
// Depends on bhc_pkg and bhc_ram.
//
// The unit takes one beat per clock unless it is sweeping or the output stalls, and answers at
// most one beat per input beat. A count beat adds one to the bin of its pixel and to the pixel
// total; a read beat returns one bin; a clear beat zeroes the store. Beats enter a two-stage
// read-modify-write loop around the bin RAM (read registered on accept, update and write back
// as the beat leaves the update stage), with the last write forwarded, so back-to-back hits on
// the same bin run at one beat per clock unless the output stalls. After reset and after each
// clear beat the RAM is swept to zero one bin per cycle with in_tready low. All counters saturate.
`timescale 1ns / 1ps
`default_nettype none

module byte_histogram_counter_unit #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // pixel [7:0], bin_index [15:8]
  input  wire logic [bhc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode [1:0]
  input  wire logic [bhc_pkg::MODE_W-1:0]       in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // bin_number [7:0], bin_count [39:8], pixels_counted [71:40]
  output logic      [bhc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // kind [0]
  output logic      [bhc_pkg::KIND_W-1:0]       out_tuser
);

  import bhc_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int XW = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (v == '1) ? v : v + COUNT_BITS'(1);
    return r;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
    logic [XW-1:0] x;
    logic [OUT_CNT_W-1:0] r;
    x = XW'(v);
    r = (x > XW'(OUT_CNT_MAX)) ? OUT_CNT_MAX : x[OUT_CNT_W-1:0];
    return r;
  endfunction

  logic [PIXEL_W-1:0] in_pixel;
  logic [INDEX_W-1:0] in_index;
  logic [INDEX_W-1:0] in_sel;
  logic               in_fire;

  logic               s1_valid_r, s1_valid_nxt;
  logic [MODE_W-1:0]  s1_mode_r;
  logic               s1_last_r;
  logic [INDEX_W-1:0] s1_idx_r;
  logic               s1_inrange_r;
  logic [AW-1:0]      s1_addr;

  logic                  clearing_r, clearing_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  wr_valid_r, wr_valid_nxt;
  logic [AW-1:0]         wr_addr_r;
  logic [COUNT_BITS-1:0] wr_data_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;

  logic                  is_count, is_read, is_clear;
  logic                  has_out, s1_fire, do_write;
  logic [COUNT_BITS-1:0] ram_rdata, cur_cnt, new_cnt;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  assign in_pixel = in_tdata[PIXEL_W-1:0];
  assign in_index = in_tdata[IN_TDATA_W-1:PIXEL_W];
  assign in_sel   = (in_tuser == MODE_READ) ? in_index : in_pixel;
  assign s1_addr  = AW'(s1_idx_r);

  assign is_count = (s1_mode_r == MODE_COUNT);
  assign is_read  = (s1_mode_r == MODE_READ);
  assign is_clear = (s1_mode_r == MODE_CLEAR);
  assign has_out  = (is_count && s1_last_r) || is_read;
  assign s1_fire  = s1_valid_r && (!has_out || !out_valid_r || out_tready);
  assign do_write = s1_fire && is_count && s1_inrange_r;

  assign in_tready = !clearing_r && (!s1_valid_r || (s1_fire && !is_clear));
  assign in_fire   = in_tvalid && in_tready;

  assign cur_cnt = (wr_valid_r && (wr_addr_r == s1_addr)) ? wr_data_r : ram_rdata;
  assign new_cnt = sat_inc(cur_cnt);

  assign ram_we    = clearing_r || do_write;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr;
  assign ram_wdata = clearing_r ? '0 : new_cnt;

  bhc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (AW'(in_sel)),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    clearing_nxt  = clearing_r;
    clr_addr_nxt  = clr_addr_r;
    total_nxt     = total_r;
    wr_valid_nxt  = wr_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end
    end
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      wr_valid_nxt = do_write;
      if (do_write) begin
        total_nxt = sat_inc(total_r);
      end
      if (is_clear) begin
        total_nxt    = '0;
        clearing_nxt = 1'b1;
        clr_addr_nxt = '0;
      end
      if (has_out) begin
        out_valid_nxt = 1'b1;
        if (is_read) begin
          out_kind_nxt = KIND_READOUT;
          out_data_nxt = {to_out(total_r),
                          s1_inrange_r ? to_out(cur_cnt) : OUT_CNT_W'(0),
                          s1_idx_r};
        end else begin
          out_kind_nxt = KIND_REPORT;
          out_data_nxt = {to_out(total_nxt), OUT_CNT_W'(0), INDEX_W'(0)};
        end
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      total_r     <= '0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      total_r     <= total_nxt;
      wr_valid_r  <= wr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_tuser;
      s1_last_r    <= in_tlast;
      s1_idx_r     <= in_sel;
      s1_inrange_r <= (32'(in_sel) < 32'(NUM_BINS));
    end
    if (do_write) begin
      wr_addr_r <= s1_addr;
      wr_data_r <= new_cnt;
    end
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // A clear beat leaving the update stage always starts the zeroing sweep.
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_clear) |=> clearing_r)
    else $error("clear beat did not start the sweep");

  // No beat may sit in the update stage while the sweep owns the RAM write port.
  a_no_beat_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_valid_r && !wr_valid_r))
    else $error("beat in flight during the clearing sweep");

  // The pixel total is zero when a sweep finishes.
  a_total_zero_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> (total_r == '0))
    else $error("pixel total not zero after the clearing sweep");

endmodule

`default_nettype wire

// ----- verif/byte_histogram_counter_unit_tb.sv -----
// Self-checking testbench for byte_histogram_counter_unit: directed and random beats with
// bursty input, a stalling receiver and a scoreboard that predicts every readout and report.
// Depends on bhc_pkg and the byte_histogram_counter_unit RTL.
`timescale 1ns / 1ps

module byte_histogram_counter_unit_tb;
  import bhc_pkg::*;

  localparam int NUM_BINS = 256;
  localparam int COUNT_BITS = 32;
  localparam int RANDOM_BEATS = 1650;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [INDEX_W-1:0] bin_number;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [OUT_CNT_W-1:0] pixels_counted;
  } hist_result_t;

  class histogram_scoreboard;
    logic [OUT_CNT_W-1:0] bin_tally[NUM_BINS];
    logic [OUT_CNT_W-1:0] pixel_sum;
    hist_result_t awaited[$];
    int mismatches;

    function void clear_store();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      pixel_sum = '0;
    endfunction

    function logic [OUT_CNT_W-1:0] bump(logic [OUT_CNT_W-1:0] v);
      return (v == OUT_CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void note_beat(logic [MODE_W-1:0] mode, logic [PIXEL_W-1:0] pixel,
                            logic is_last, logic [INDEX_W-1:0] index);
      hist_result_t r;
      case (mode)
        MODE_COUNT: begin
          if (pixel < NUM_BINS) begin
            bin_tally[pixel] = bump(bin_tally[pixel]);
            pixel_sum = bump(pixel_sum);
          end
          if (is_last) begin
            r.kind = KIND_REPORT;
            r.bin_number = '0;
            r.bin_count = '0;
            r.pixels_counted = pixel_sum;
            awaited.push_back(r);
          end
        end
        MODE_READ: begin
          r.kind = KIND_READOUT;
          r.bin_number = index;
          r.bin_count = (index < NUM_BINS) ? bin_tally[index] : '0;
          r.pixels_counted = pixel_sum;
          awaited.push_back(r);
        end
        MODE_CLEAR: clear_store();
        default: ;
      endcase
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] tdata, logic [KIND_W-1:0] tuser);
      hist_result_t want;
      hist_result_t got;
      got.kind = tuser;
      got.bin_number = tdata[7:0];
      got.bin_count = tdata[39:8];
      got.pixels_counted = tdata[71:40];
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result beat kind %0d bin %0d count %0d total %0d",
                   $time, got.kind, got.bin_number, got.bin_count, got.pixels_counted);
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind || got.bin_number != want.bin_number ||
          got.bin_count != want.bin_count || got.pixels_counted != want.pixels_counted) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"%0t: bad result beat (expected/actual) kind %0d/%0d bin %0d/%0d ",
                    "count %0d/%0d total %0d/%0d"}, $time, want.kind, got.kind,
                   want.bin_number, got.bin_number, want.bin_count, got.bin_count,
                   want.pixels_counted, got.pixels_counted);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;

  histogram_scoreboard sb;
  int beats_sent;
  int burst_left;
  int quiet_cycles;
  int stall_left;
  int stall_style;
  int unsigned tick;

  always #5 clk = ~clk;

  byte_histogram_counter_unit #(
    .NUM_BINS(NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
    if (rst_n && in_tvalid && in_tready)
      sb.note_beat(in_tuser, in_tdata[7:0], in_tlast, in_tdata[15:8]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    tick <= tick + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (tick[2:0] != 3'd5) && (tick[3:0] != 4'd9);
    endcase
  end

  task automatic push_beat(logic [MODE_W-1:0] mode, logic [PIXEL_W-1:0] pixel,
                           logic is_last, logic [INDEX_W-1:0] index);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {index, pixel};
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
    if (mode != MODE_UNUSED) beats_sent++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 8);
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250) : $urandom_range(0, 12);
    in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // The wait before polling the queue lets the monitor note the beat accepted at the last edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_image();
    int len;
    int flavor;
    logic [PIXEL_W-1:0] base;
    logic [PIXEL_W-1:0] pix;
    len = $urandom_range(1, 40);
    flavor = $urandom_range(0, 2);
    base = PIXEL_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (flavor)
        0: pix = PIXEL_W'($urandom_range(0, 255));
        1: pix = base + PIXEL_W'($urandom_range(0, 3));
        default: pix = base;
      endcase
      push_beat(MODE_COUNT, pix, i == len - 1, INDEX_W'($urandom_range(0, 255)));
      pace();
      if ($urandom_range(0, 7) == 0) begin
        push_beat(MODE_READ, PIXEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 0) ? pix : 8'($urandom_range(0, 255)));
        pace();
      end
    end
  endtask

  initial begin
    int pick;
    bit drained;
    sb = new;
    sb.clear_store();
    drained = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(MODE_COUNT, 8'd0, 1'b0, 8'd255);
    push_beat(MODE_COUNT, 8'd255, 1'b0, 8'd0);
    push_beat(MODE_COUNT, 8'd255, 1'b1, 8'd0);
    push_beat(MODE_READ, 8'd255, 1'b0, 8'd0);
    push_beat(MODE_READ, 8'd0, 1'b0, 8'd255);
    push_beat(MODE_READ, 8'd85, 1'b0, 8'd170);
    push_beat(MODE_READ, 8'd170, 1'b1, 8'd85);
    push_beat(MODE_COUNT, 8'd170, 1'b0, 8'd85);
    push_beat(MODE_COUNT, 8'd85, 1'b1, 8'd170);
    push_beat(MODE_UNUSED, 8'd255, 1'b1, 8'd255);
    push_beat(MODE_UNUSED, 8'd0, 1'b0, 8'd0);
    push_beat(MODE_READ, 8'd0, 1'b0, 8'd85);
    push_beat(MODE_CLEAR, 8'd255, 1'b1, 8'd255);
    push_beat(MODE_READ, 8'd0, 1'b0, 8'd255);
    push_beat(MODE_COUNT, 8'd255, 1'b1, 8'd0);
    repeat (4) push_beat(MODE_COUNT, 8'd7, 1'b0, 8'd7);
    push_beat(MODE_READ, 8'd7, 1'b0, 8'd7);
    push_beat(MODE_COUNT, 8'd7, 1'b1, 8'd7);
    push_beat(MODE_READ, 8'd0, 1'b0, 8'd7);
    push_beat(MODE_CLEAR, 8'd0, 1'b0, 8'd0);
    push_beat(MODE_READ, 8'd0, 1'b0, 8'd7);
    push_beat(MODE_READ, 8'd0, 1'b1, 8'd255);

    beats_sent = 0;
    burst_left = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (!drained && beats_sent > RANDOM_BEATS / 2) begin
        drain();
        drained = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        push_beat(MODE_CLEAR, PIXEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  INDEX_W'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        push_beat(MODE_UNUSED, PIXEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  INDEX_W'($urandom_range(0, 255)));
      end else if (pick < 15) begin
        push_beat(MODE_READ, PIXEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  INDEX_W'($urandom_range(0, 255)));
      end else begin
        send_image();
      end
      pace();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bhc_pkg.sv
rtl/core/bhc_ram.sv
rtl/core/byte_histogram_counter_unit.sv
verif/byte_histogram_counter_unit_tb.sv
